### sv/pcsv_pkg.sv
// Package for the PNG chunk stream validator.
// Holds the request and verdict types, the error codes, the phase enum
// and the CRC-32 byte step. No dependencies.
package pcsv_pkg;

    localparam int LEN_W = 32;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [31:0] CASE_FOLD = 32'hDFDFDFDF;
    localparam logic [31:0] WORD_IHDR = 32'h49484452;
    localparam logic [31:0] WORD_IDAT = 32'h49444154;
    localparam logic [31:0] WORD_IEND = 32'h49454E44;
    localparam logic [LEN_W-1:0] MIN_WINDOW = LEN_W'(44);
    localparam logic [LEN_W:0] CHUNK_OVERHEAD = (LEN_W+1)'(12);
    localparam logic [LEN_W-1:0] HDR_BYTES = LEN_W'(8);

    localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};

    typedef enum logic [3:0] {
        ERR_OK       = 4'd0,
        ERR_SHORT    = 4'd1,
        ERR_SIG      = 4'd2,
        ERR_TYPE     = 4'd3,
        ERR_OVERRUN  = 4'd4,
        ERR_CRC      = 4'd5,
        ERR_NOT_IHDR = 4'd6,
        ERR_NO_IDAT  = 4'd7,
        ERR_NO_IEND  = 4'd8
    } err_t;

    typedef enum logic [2:0] {
        PH_DONE = 3'd0,
        PH_SIG  = 3'd1,
        PH_HDR  = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        start_of_window;
        logic [31:0] window_length;
    } item_t;

    typedef struct packed {
        logic        is_valid;
        logic [31:0] valid_length;
        logic [3:0]  error_code;
    } verdict_t;

    // Verdict handed from the chunk walker to the output stage.
    typedef struct packed {
        logic     fire;
        verdict_t data;
    } verdict_req_t;

    // One byte step of the reflected PNG CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

### sv/pcsv_item_if.sv
// Valid/ready channel carrying one window byte per request.
// Depends on pcsv_pkg.
interface pcsv_item_if;
    import pcsv_pkg::*;

    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic        start_of_window;
    logic [31:0] window_length;

    modport source (output valid, byte_value, start_of_window, window_length,
                    input ready);
    modport sink (input valid, byte_value, start_of_window, window_length,
                  output ready);
endinterface

### sv/pcsv_verdict_if.sv
// Valid/ready channel carrying one verdict per request.
// Depends on pcsv_pkg.
interface pcsv_verdict_if;
    import pcsv_pkg::*;

    logic        valid;
    logic        ready;
    logic        is_valid;
    logic [31:0] valid_length;
    logic [3:0]  error_code;

    modport source (output valid, is_valid, valid_length, error_code,
                    input ready);
    modport sink (input valid, is_valid, valid_length, error_code,
                  output ready);
endinterface

### sv/png_chunk_stream_validator_top.sv
// PNG chunk stream validator, top level.
// Byte in, verdict out. Usage:
//   The bytes channel takes one byte of a candidate PNG per request. A
//   request with start_of_window high opens a new window of window_length
//   bytes; that byte is the first byte of the window. A start in the middle
//   of a window drops the old window without a verdict.
//   The verdicts channel gives at most one request per window: is_valid, the length
//   through the IEND chunk, and an error code. Bytes that follow a verdict
//   are ignored until the next start.
//   Path: a byte is held in an input register and checked in the chunk
//   walker. Its verdict, if any, is loaded into the output register when
//   the output slot is free, and is offered on the verdicts channel.
//   Throughput: one byte per cycle, unless stalled as below; set by the
//   combinational CRC-32 byte step and the length/fit compare in the walker.
//   Reset: no window is open after reset; bytes are ignored until a start.
//   Stall: while a verdict waits on the verdicts channel, bytes that give no
//   verdict still flow; a byte that would give a second verdict waits in the
//   input register, and the bytes channel stalls behind it.
// Depends on pcsv_pkg, pcsv_item_if, pcsv_verdict_if, pcsv_walker.
module png_chunk_stream_validator_top
    import pcsv_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    pcsv_item_if.sink       bytes,
    pcsv_verdict_if.source  verdicts
);

    logic         in_valid_reg;
    item_t        in_item_reg;
    logic         out_valid_reg, out_valid_next;
    verdict_t     out_data_reg;
    verdict_req_t verdict;
    logic         consume, load;

    // The held byte leaves when it makes no verdict or the output slot frees.
    assign consume = in_valid_reg &&
                     (!verdict.fire || !out_valid_reg || verdicts.ready);
    assign load    = consume && verdict.fire;
    assign bytes.ready = !in_valid_reg || consume;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (bytes.ready)
            in_valid_reg <= bytes.valid;
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            in_item_reg.byte_value      <= bytes.byte_value;
            in_item_reg.start_of_window <= bytes.start_of_window;
            in_item_reg.window_length   <= bytes.window_length;
        end
    end

    pcsv_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (in_item_reg),
        .item_valid (in_valid_reg),
        .step       (consume),
        .verdict    (verdict)
    );

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (verdicts.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= verdict.data;
    end

    assign verdicts.valid        = out_valid_reg;
    assign verdicts.is_valid     = out_data_reg.is_valid;
    assign verdicts.valid_length = out_data_reg.valid_length;
    assign verdicts.error_code   = out_data_reg.error_code;

endmodule

### sv/pcsv_walker.sv
// Chunk walker: per-window state and the per-byte checks of the validator.
// Depends on pcsv_pkg.
module pcsv_walker
    import pcsv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  item_t        item,
    input  logic         item_valid,
    input  logic         step,
    output verdict_req_t verdict
);

    phase_t             phase_reg, phase_next;
    logic [2:0]         fbc_reg, fbc_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   wsize_reg, wsize_next;
    logic [31:0]        clen_reg, clen_next;
    logic [31:0]        left_reg, left_next;
    logic [31:0]        type_reg, type_next;
    logic [31:0]        crc_reg, crc_next;
    logic [31:0]        stored_reg, stored_next;
    logic               first_reg, first_next;
    logic               seen_reg, seen_next;

    // Effective state once a start has cleared the window.
    logic               start, short_win, active;
    phase_t             eff_phase;
    logic [2:0]         eff_fbc;
    logic [LEN_W-1:0]   eff_pos, eff_ws, pos_inc;
    logic               eff_first, eff_seen;
    logic [7:0]         b;

    // Per-phase intermediate values.
    logic [31:0]        hdr_len, hdr_type, hdr_crc_in, hdr_crc, data_crc, stored_new;
    logic [31:0]        folded;
    logic [LEN_W-1:0]   chunk_start, remaining;
    logic               type_bad, overrun;
    logic               fire;
    err_t               code;

    assign b         = item.byte_value;
    assign start     = item.start_of_window;
    assign eff_ws    = start ? item.window_length[LEN_W-1:0] : wsize_reg;
    assign short_win = start && (eff_ws < MIN_WINDOW);
    assign eff_phase = start ? PH_SIG : phase_reg;
    assign eff_fbc   = start ? 3'd0 : fbc_reg;
    assign eff_pos   = start ? '0 : pos_reg;
    assign eff_first = start ? 1'b1 : first_reg;
    assign eff_seen  = start ? 1'b0 : seen_reg;
    assign active    = start ? !short_win : (phase_reg != PH_DONE);
    assign pos_inc   = eff_pos + LEN_W'(1);

    // Header bytes: four length bytes, then four type bytes under the CRC.
    assign hdr_len    = (eff_fbc < 3'd4) ? {clen_reg[23:0], b} : clen_reg;
    assign hdr_type   = (eff_fbc >= 3'd4) ? {type_reg[23:0], b} : type_reg;
    assign hdr_crc_in = (eff_fbc == 3'd0) ? CRC_INIT : crc_reg;
    assign hdr_crc    = (eff_fbc >= 3'd4) ? crc_byte(hdr_crc_in, b) : hdr_crc_in;
    assign data_crc   = crc_byte(crc_reg, b);
    assign stored_new = {stored_reg[23:0], b};
    assign folded     = type_reg & CASE_FOLD;

    // Type letters and chunk fit, checked with the last header byte.
    assign type_bad    = !(is_letter(hdr_type[7:0]) && is_letter(hdr_type[15:8]) &&
                           is_letter(hdr_type[23:16]) && is_letter(hdr_type[31:24]));
    assign chunk_start = pos_inc - HDR_BYTES;
    assign remaining   = eff_ws - chunk_start;
    assign overrun     = ({1'b0, hdr_len} + CHUNK_OVERHEAD) > {1'b0, remaining};

    // Verdict decision for the byte at hand.
    always_comb
    begin
        fire = 1'b0;
        code = ERR_OK;
        if (short_win)
        begin
            fire = 1'b1;
            code = ERR_SHORT;
        end
        else if (active)
        begin
            case (eff_phase)
                PH_SIG:
                begin
                    if (b != PNG_SIG[eff_fbc])
                    begin
                        fire = 1'b1;
                        code = ERR_SIG;
                    end
                end
                PH_HDR:
                begin
                    if (eff_fbc == 3'd7)
                    begin
                        if (type_bad)
                        begin
                            fire = 1'b1;
                            code = ERR_TYPE;
                        end
                        else if (overrun)
                        begin
                            fire = 1'b1;
                            code = ERR_OVERRUN;
                        end
                    end
                end
                PH_CRC:
                begin
                    if (eff_fbc == 3'd3)
                    begin
                        fire = 1'b1;
                        if (stored_new != ~crc_reg)
                            code = ERR_CRC;
                        else if (eff_first && (folded != WORD_IHDR))
                            code = ERR_NOT_IHDR;
                        else if (folded == WORD_IEND)
                            code = eff_seen ? ERR_OK : ERR_NO_IDAT;
                        else if (pos_inc >= eff_ws)
                            code = ERR_NO_IEND;
                        else
                            fire = 1'b0;
                    end
                end
                default:
                begin
                    fire = 1'b0;
                end
            endcase
        end
    end

    // Verdict payload.
    always_comb
    begin
        verdict.fire              = item_valid && fire;
        verdict.data.is_valid     = (code == ERR_OK);
        verdict.data.valid_length = (code == ERR_OK) ? 32'(pos_inc) : 32'd0;
        verdict.data.error_code   = code;
    end

    // Next state.
    always_comb
    begin
        phase_next  = phase_reg;
        fbc_next    = fbc_reg;
        pos_next    = pos_reg;
        wsize_next  = wsize_reg;
        clen_next   = clen_reg;
        left_next   = left_reg;
        type_next   = type_reg;
        crc_next    = crc_reg;
        stored_next = stored_reg;
        first_next  = first_reg;
        seen_next   = seen_reg;
        if (start)
        begin
            fbc_next    = 3'd0;
            pos_next    = '0;
            wsize_next  = eff_ws;
            clen_next   = 32'd0;
            left_next   = 32'd0;
            type_next   = 32'd0;
            crc_next    = CRC_INIT;
            stored_next = 32'd0;
            first_next  = 1'b1;
            seen_next   = 1'b0;
            phase_next  = PH_DONE;
        end
        if (active)
        begin
            pos_next = pos_inc;
            case (eff_phase)
                PH_SIG:
                begin
                    if (eff_fbc == 3'd7)
                    begin
                        fbc_next   = 3'd0;
                        phase_next = PH_HDR;
                    end
                    else
                    begin
                        fbc_next   = eff_fbc + 3'd1;
                        phase_next = PH_SIG;
                    end
                end
                PH_HDR:
                begin
                    clen_next = hdr_len;
                    type_next = hdr_type;
                    crc_next  = hdr_crc;
                    if (eff_fbc == 3'd0)
                        stored_next = 32'd0;
                    fbc_next = eff_fbc + 3'd1;
                    if (eff_fbc == 3'd7)
                    begin
                        fbc_next   = 3'd0;
                        left_next  = hdr_len;
                        phase_next = (hdr_len != 32'd0) ? PH_DATA : PH_CRC;
                    end
                end
                PH_DATA:
                begin
                    crc_next  = data_crc;
                    left_next = left_reg - 32'd1;
                    if (left_reg == 32'd1)
                        phase_next = PH_CRC;
                end
                PH_CRC:
                begin
                    stored_next = stored_new;
                    fbc_next    = eff_fbc + 3'd1;
                    if (eff_fbc == 3'd3)
                    begin
                        fbc_next   = 3'd0;
                        phase_next = PH_HDR;
                        if (stored_new == ~crc_reg &&
                            !(eff_first && (folded != WORD_IHDR)))
                        begin
                            first_next = 1'b0;
                            if (folded == WORD_IDAT)
                                seen_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
            if (fire)
                phase_next = PH_DONE;
        end
    end

    // State registers advance only on a consumed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DONE;
            fbc_reg    <= 3'd0;
            pos_reg    <= '0;
            wsize_reg  <= '0;
            clen_reg   <= 32'd0;
            left_reg   <= 32'd0;
            type_reg   <= 32'd0;
            crc_reg    <= CRC_INIT;
            stored_reg <= 32'd0;
            first_reg  <= 1'b1;
            seen_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            fbc_reg    <= fbc_next;
            pos_reg    <= pos_next;
            wsize_reg  <= wsize_next;
            clen_reg   <= clen_next;
            left_reg   <= left_next;
            type_reg   <= type_next;
            crc_reg    <= crc_next;
            stored_reg <= stored_next;
            first_reg  <= first_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

### bench/tb_top.sv
// Self-checking bench for png_chunk_stream_validator_top: builds PNG windows, drives them
// byte by byte with random gaps and checks every verdict against a local chunk walker.
// Depends on pcsv_pkg, pcsv_item_if, pcsv_verdict_if and the validator RTL.
`timescale 1ns / 100ps

module tb_top;
    import pcsv_pkg::*;

    localparam logic [63:0] PNG_MAGIC   = 64'h89504E470D0A1A0A;
    localparam logic [31:0] CRC32_POLY  = 32'hEDB88320;
    localparam logic [31:0] LETTER_FOLD = 32'hDFDFDFDF;
    localparam logic [31:0] TYPE_IHDR   = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT   = 32'h49444154;
    localparam logic [31:0] TYPE_IEND   = 32'h49454E44;
    localparam logic [31:0] TYPE_TEXT   = 32'h74455874;
    localparam logic [95:0] IEND_RAW    = 96'h00000000_49454E44_AE426082;
    localparam int          SHORTEST    = 44;
    localparam int          LONG_HOLD   = 400;

    typedef enum logic [2:0] {
        W_IDLE,
        W_SIG,
        W_HDR,
        W_DATA,
        W_CRC
    } walk_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    pcsv_item_if    bytes_ch ();
    pcsv_verdict_if verdict_ch ();

    png_chunk_stream_validator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (bytes_ch),
        .verdicts (verdict_ch)
    );

    always #10 clk = ~clk;

    // Bytes waiting to be offered, and verdicts that the walker says must come.
    item_t      byte_backlog [$];
    verdict_t   due_verdicts [$];
    logic [7:0] img [$];
    item_t      on_bus;
    verdict_t   want;

    int bytes_queued = 0;
    int bytes_taken  = 0;
    int n_checked    = 0;
    int errors       = 0;
    int tx_gap, tx_burst, rx_gap, rx_burst, hold_left;
    bit hold_used;

    // Chunk walker state, one copy of what the block tracks per window.
    walk_phase_t walk_ph = W_IDLE;
    int          fcnt;
    logic [31:0] pos, win, clen, dleft, tword, crc_acc, crc_seen;
    logic        first_chunk, idat_seen;

    function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'h0, b};
        repeat (8) c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
        return c;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return ((c & 8'hDF) >= 8'h41) && ((c & 8'hDF) <= 8'h5A);
    endfunction

    // Mostly no gap, some short ones, a few long ones, and now and then a gap-free burst.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_walk();
        fcnt        = 0;
        pos         = '0;
        win         = '0;
        clen        = '0;
        dleft       = '0;
        tword       = '0;
        crc_acc     = '1;
        crc_seen    = '0;
        first_chunk = 1'b1;
        idat_seen   = 1'b0;
    endtask

    task automatic post_verdict(input err_t code, input logic [31:0] len);
        verdict_t v;
        v.is_valid     = (code == ERR_OK);
        v.valid_length = (code == ERR_OK) ? len : 32'h0;
        v.error_code   = code;
        due_verdicts.push_back(v);
        walk_ph = W_IDLE;
    endtask

    // Advance the walker by one accepted byte and queue the verdict it causes, if any.
    task automatic walk_png_byte(input item_t it);
        logic [7:0]  b;
        logic [31:0] chunk_at, room, folded;
        b = it.byte_value;
        if (it.start_of_window)
        begin
            clear_walk();
            win = it.window_length;
            if (win < SHORTEST)
            begin
                post_verdict(ERR_SHORT, '0);
                return;
            end
            walk_ph = W_SIG;
        end
        else if (walk_ph == W_IDLE)
            return;
        pos = pos + 32'd1;
        case (walk_ph)
            W_SIG:
            begin
                if (b != PNG_MAGIC[63 - 8 * fcnt -: 8])
                    post_verdict(ERR_SIG, '0);
                else
                begin
                    fcnt++;
                    if (fcnt == 8)
                    begin
                        fcnt    = 0;
                        walk_ph = W_HDR;
                    end
                end
            end
            W_HDR:
            begin
                if (fcnt == 0)
                begin
                    crc_acc  = '1;
                    crc_seen = '0;
                end
                if (fcnt < 4)
                    clen = {clen[23:0], b};
                else
                begin
                    tword   = {tword[23:0], b};
                    crc_acc = crc32_step(crc_acc, b);
                end
                fcnt++;
                if (fcnt == 8)
                begin
                    fcnt     = 0;
                    chunk_at = pos - 32'd8;
                    room     = win - chunk_at;
                    if (!(is_alpha(tword[31:24]) && is_alpha(tword[23:16]) &&
                          is_alpha(tword[15:8]) && is_alpha(tword[7:0])))
                        post_verdict(ERR_TYPE, '0);
                    else if ({1'b0, clen} + 33'd12 > {1'b0, room})
                        post_verdict(ERR_OVERRUN, '0);
                    else
                    begin
                        dleft   = clen;
                        walk_ph = (clen != 0) ? W_DATA : W_CRC;
                    end
                end
            end
            W_DATA:
            begin
                crc_acc = crc32_step(crc_acc, b);
                dleft   = dleft - 32'd1;
                if (dleft == 0)
                    walk_ph = W_CRC;
            end
            default:
            begin
                crc_seen = {crc_seen[23:0], b};
                fcnt++;
                if (fcnt == 4)
                begin
                    fcnt   = 0;
                    folded = tword & LETTER_FOLD;
                    if (crc_seen != ~crc_acc)
                        post_verdict(ERR_CRC, '0);
                    else if (first_chunk && folded != TYPE_IHDR)
                        post_verdict(ERR_NOT_IHDR, '0);
                    else
                    begin
                        first_chunk = 1'b0;
                        if (folded == TYPE_IDAT)
                            idat_seen = 1'b1;
                        if (folded == TYPE_IEND)
                        begin
                            if (!idat_seen)
                                post_verdict(ERR_NO_IDAT, '0);
                            else
                                post_verdict(ERR_OK, pos);
                        end
                        else if (pos >= win)
                            post_verdict(ERR_NO_IEND, '0);
                        else
                            walk_ph = W_HDR;
                    end
                end
            end
        endcase
    endtask

    // Helpers that build a candidate file in img.
    function automatic logic [7:0] letter_byte();
        return 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h61 : 8'h41);
    endfunction

    function automatic logic [31:0] any_type();
        return {letter_byte(), letter_byte(), letter_byte(), letter_byte()};
    endfunction

    function automatic logic [31:0] case_scramble(input logic [31:0] w);
        return w ^ ($urandom & 32'h20202020);
    endfunction

    function automatic logic [7:0] non_letter();
        logic [7:0] c;
        do c = 8'($urandom); while (is_alpha(c));
        return c;
    endfunction

    function automatic logic [7:0] filler_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic int chunk_size();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    endfunction

    task automatic put_sig();
        for (int i = 7; i >= 0; i--)
            img.push_back(PNG_MAGIC[8 * i +: 8]);
    endtask

    // Length field, type, n_data bytes of filler, then the CRC flipped by crc_xor.
    task automatic put_chunk(input logic [31:0] len_field, input logic [31:0] tw,
                             input int n_data, input logic [31:0] crc_xor);
        logic [31:0] acc;
        logic [7:0]  d;
        acc = '1;
        for (int i = 3; i >= 0; i--)
            img.push_back(len_field[8 * i +: 8]);
        for (int i = 3; i >= 0; i--)
        begin
            img.push_back(tw[8 * i +: 8]);
            acc = crc32_step(acc, tw[8 * i +: 8]);
        end
        repeat (n_data)
        begin
            d = filler_byte();
            img.push_back(d);
            acc = crc32_step(acc, d);
        end
        acc = ~acc ^ crc_xor;
        for (int i = 3; i >= 0; i--)
            img.push_back(acc[8 * i +: 8]);
    endtask

    // Queue the first keep bytes of img as one window; the window length rides on byte 0.
    task automatic send_window(input logic [31:0] wl, input int keep);
        item_t it;
        for (int i = 0; i < keep && i < img.size(); i++)
        begin
            it.byte_value      = img[i];
            it.start_of_window = (i == 0);
            it.window_length   = (i == 0) ? wl : $urandom;
            byte_backlog.push_back(it);
        end
        img.delete();
    endtask

    task automatic put_noise(input int n);
        item_t it;
        repeat (n)
        begin
            it.byte_value      = 8'($urandom);
            it.start_of_window = 1'b0;
            it.window_length   = $urandom;
            byte_backlog.push_back(it);
        end
    endtask

    // One random window: about half well-formed files, the rest broken in one chosen way.
    task automatic random_window();
        int          kind, n_mid, bad_crc_at, bad_type_at, base, slack, keep, p, len;
        logic [31:0] wl, tw, big_len;
        bit          no_idat, saw_idat;
        kind = $urandom_range(0, 99);
        img.delete();
        if (kind < 4)
        begin
            repeat ($urandom_range(1, 12)) img.push_back(8'($urandom));
            send_window($urandom_range(SHORTEST, 300), img.size());
            return;
        end
        if (kind < 9)
        begin
            img.push_back(8'($urandom));
            send_window($urandom_range(0, SHORTEST - 1), 1);
            return;
        end
        n_mid   = $urandom_range(0, 3);
        no_idat = (kind >= 27 && kind < 32);
        if (!no_idat && n_mid == 0)
            n_mid = 1;
        bad_crc_at  = (kind >= 16 && kind < 22) ? $urandom_range(0, n_mid + 1) : -1;
        bad_type_at = (kind >= 22 && kind < 27) ? $urandom_range(0, n_mid + 1) : -1;
        saw_idat    = 1'b0;
        put_sig();
        if (kind < 12)
        begin
            p = $urandom_range(0, 7);
            img[p] = img[p] ^ 8'(1 << $urandom_range(0, 7));
        end
        for (int c = 0; c <= n_mid + 1; c++)
        begin
            // The missing-IEND and overrun cases stop before the closing chunk.
            if (c == n_mid + 1 && kind >= 32 && kind < 46)
                break;
            if (c == 0)
                tw = (kind >= 12 && kind < 16) ? any_type() : case_scramble(TYPE_IHDR);
            else if (c == n_mid + 1)
                tw = case_scramble(TYPE_IEND);
            else if (no_idat)
            begin
                do tw = any_type(); while ((tw & LETTER_FOLD) == TYPE_IDAT);
            end
            else if (!saw_idat && (c == n_mid || $urandom_range(0, 1)))
                tw = case_scramble(TYPE_IDAT);
            else
                tw = ($urandom_range(0, 2) == 0) ? case_scramble(TYPE_IDAT) : any_type();
            if ((tw & LETTER_FOLD) == TYPE_IDAT)
                saw_idat = 1'b1;
            if (c == bad_type_at)
            begin
                p = $urandom_range(0, 3);
                tw[8 * p +: 8] = non_letter();
            end
            len = chunk_size();
            put_chunk(32'(len), tw, len,
                      (c == bad_crc_at) ? (32'h1 << $urandom_range(0, 31)) : 32'h0);
        end
        if (kind >= 38 && kind < 46)
        begin
            // A last chunk that cannot fit: just past the end, far past it, or huge.
            base  = img.size();
            slack = $urandom_range(1, 20);
            wl    = 32'(base + slack);
            case ($urandom_range(0, 2))
                0: big_len = (slack >= 12) ? 32'(slack - 11 + $urandom_range(0, 3))
                                           : 32'($urandom_range(0, 5));
                1: big_len = $urandom | 32'h0001_0000;
                default:
                begin
                    big_len = 32'hFFFF_FFF4 + 32'($urandom_range(0, 11));
                    wl      = 32'hFFFF_FFFF;
                end
            endcase
            put_chunk(big_len, any_type(), 0, 32'h0);
            send_window(wl, img.size());
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:    wl = 32'(img.size() + $urandom_range(1, 30));
                2:       wl = $urandom_range(32'hFFFF_FFFF, img.size());
                default: wl = 32'(img.size());
            endcase
            keep = (kind >= 46 && kind < 52) ? $urandom_range(1, img.size() - 1) : img.size();
            send_window(wl, keep);
        end
        if ($urandom_range(0, 4) == 0)
            put_noise($urandom_range(1, 6));
    endtask

    // Sender: offers queued bytes, with gaps, and steps the walker on each accepted request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_ch.valid           <= 1'b0;
            bytes_ch.byte_value      <= 8'h00;
            bytes_ch.start_of_window <= 1'b0;
            bytes_ch.window_length   <= 32'h0;
            tx_gap   = 0;
            tx_burst = 0;
            clear_walk();
            walk_ph = W_IDLE;
        end
        else
        begin
            if (bytes_ch.valid && bytes_ch.ready)
            begin
                walk_png_byte(on_bus);
                bytes_taken++;
            end
            if (!bytes_ch.valid || bytes_ch.ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    bytes_ch.valid <= 1'b0;
                end
                else if (byte_backlog.size() > 0)
                begin
                    on_bus = byte_backlog.pop_front();
                    bytes_ch.valid           <= 1'b1;
                    bytes_ch.byte_value      <= on_bus.byte_value;
                    bytes_ch.start_of_window <= on_bus.start_of_window;
                    bytes_ch.window_length   <= on_bus.window_length;
                    tx_gap = pick_gap(tx_burst);
                end
                else
                    bytes_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each verdict against the oldest one due, and throttles ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_ch.ready <= 1'b0;
            rx_gap    = 0;
            rx_burst  = 0;
            hold_left = 0;
            hold_used = 1'b0;
        end
        else
        begin
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                if (due_verdicts.size() == 0)
                begin
                    $display("%0t: verdict with none due: is_valid=%0b valid_length=%0d error_code=%0d",
                             $time, verdict_ch.is_valid, verdict_ch.valid_length,
                             verdict_ch.error_code);
                    errors++;
                end
                else
                begin
                    want = due_verdicts.pop_front();
                    if (verdict_ch.is_valid !== want.is_valid)
                    begin
                        $display("%0t: is_valid expected %0b, got %0b",
                                 $time, want.is_valid, verdict_ch.is_valid);
                        errors++;
                    end
                    if (verdict_ch.valid_length !== want.valid_length)
                    begin
                        $display("%0t: valid_length expected %0d, got %0d",
                                 $time, want.valid_length, verdict_ch.valid_length);
                        errors++;
                    end
                    if (verdict_ch.error_code !== want.error_code)
                    begin
                        $display("%0t: error_code expected %0d, got %0d",
                                 $time, want.error_code, verdict_ch.error_code);
                        errors++;
                    end
                end
                n_checked++;
                rx_gap = pick_gap(rx_burst);
            end
            else if (rx_gap == 0 && $urandom_range(0, 19) == 0)
                rx_gap = pick_gap(rx_burst);

            // One long hold-off so the block backs up and stalls its byte input.
            if (hold_left > 0)
            begin
                hold_left--;
                verdict_ch.ready <= 1'b0;
            end
            else if (!hold_used && n_checked >= 12)
            begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
                verdict_ch.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                verdict_ch.ready <= 1'b0;
            end
            else
                verdict_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n <= 1'b0;

        // Bytes before the first start are ignored.
        put_noise(3);

        // Windows of length zero and one below the minimum; trailing bytes are ignored.
        img.push_back(8'h89);
        send_window(32'd0, 1);
        put_noise(2);
        put_sig();
        send_window(32'd43, 3);

        // Smallest valid file, with the IEND chunk written out with its standard CRC.
        put_sig();
        put_chunk(32'd0, TYPE_IHDR, 0, 32'h0);
        put_chunk(32'd0, TYPE_IDAT, 0, 32'h0);
        for (int i = 11; i >= 0; i--)
            img.push_back(IEND_RAW[8 * i +: 8]);
        send_window(32'd44, img.size());

        // Lower-case type names in the largest window.
        put_sig();
        put_chunk(32'd13, TYPE_IHDR | 32'h20202020, 13, 32'h0);
        put_chunk(32'd5, TYPE_IDAT | 32'h20202020, 5, 32'h0);
        put_chunk(32'd0, TYPE_IEND | 32'h20202020, 0, 32'h0);
        send_window(32'hFFFF_FFFF, img.size());

        // Signature wrong at its first and at its last byte.
        img.push_back(8'h00);
        send_window(32'd100, 1);
        put_sig();
        img[7] = 8'hFF;
        send_window(32'd100, 8);

        // Type bytes just outside the letter ranges.
        put_sig();
        put_chunk(32'd0, 32'h49484052, 0, 32'h0);
        send_window(32'd100, img.size());
        put_sig();
        put_chunk(32'd0, 32'h4948447B, 0, 32'h0);
        send_window(32'd100, img.size());

        // Largest length field: the fit check must not wrap.
        put_sig();
        put_chunk(32'hFFFF_FFFF, TYPE_IHDR, 0, 32'h0);
        send_window(32'hFFFF_FFFF, img.size());

        // Next chunk header lies partly past the window end.
        put_sig();
        put_chunk(32'd0, TYPE_IHDR, 0, 32'h0);
        put_chunk(32'd0, TYPE_IDAT, 0, 32'h0);
        put_chunk(32'd0, TYPE_TEXT, 0, 32'h0);
        put_chunk(32'd0, TYPE_IEND, 0, 32'h0);
        send_window(32'd50, img.size());

        // Chunk one byte too long for the window.
        put_sig();
        put_chunk(32'd0, TYPE_IHDR, 0, 32'h0);
        put_chunk(32'd1, TYPE_IDAT, 1, 32'h0);
        send_window(32'(img.size() - 1), img.size());

        // CRC mismatch.
        put_sig();
        put_chunk(32'd2, TYPE_IHDR, 2, 32'h8000_0000);
        send_window(32'(img.size()), img.size());

        // First chunk not IHDR.
        put_sig();
        put_chunk(32'd3, TYPE_IDAT, 3, 32'h0);
        send_window(32'd100, img.size());

        // IEND with no IDAT before it.
        put_sig();
        put_chunk(32'd1, TYPE_IHDR, 1, 32'h0);
        put_chunk(32'd0, TYPE_IEND, 0, 32'h0);
        send_window(32'(img.size()), img.size());

        // Window used up exactly by a chunk that is not IEND.
        put_sig();
        put_chunk(32'd1, TYPE_IHDR, 1, 32'h0);
        put_chunk(32'd3, TYPE_IDAT, 3, 32'h0);
        send_window(32'(img.size()), img.size());

        // Error order: a bad CRC wins over not-IHDR, and not-IHDR over missing IDAT.
        put_sig();
        put_chunk(32'd0, TYPE_IEND, 0, 32'h0000_0001);
        send_window(32'd100, img.size());
        put_sig();
        put_chunk(32'd0, TYPE_IEND, 0, 32'h0);
        send_window(32'd100, img.size());

        // A start in the middle of a window drops it without a verdict.
        put_sig();
        put_chunk(32'd4, TYPE_IHDR, 4, 32'h0);
        put_chunk(32'd2, TYPE_IDAT, 2, 32'h0);
        put_chunk(32'd0, TYPE_IEND, 0, 32'h0);
        send_window(32'(img.size()), 20);
        put_sig();
        put_chunk(32'd4, TYPE_IHDR, 4, 32'h0);
        put_chunk(32'd2, TYPE_IDAT, 2, 32'h0);
        put_chunk(32'd0, TYPE_IEND, 0, 32'h0);
        send_window(32'(img.size()), img.size());

        while (byte_backlog.size() < 1450)
            random_window();
        bytes_queued = byte_backlog.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != bytes_queued)
            @(posedge clk);
        while (due_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("** png_chunk_stream_validator_top: PASSED **");
        else
            $display("** png_chunk_stream_validator_top: FAILED **");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #(20_000_000);
        $display("%0t: run limit reached", $time);
        $display("** png_chunk_stream_validator_top: FAILED **");
        $finish;
    end

endmodule

### png_chunk_stream_validator_top.f
sv/pcsv_pkg.sv
sv/pcsv_item_if.sv
sv/pcsv_verdict_if.sv
sv/pcsv_walker.sv
sv/png_chunk_stream_validator_top.sv
bench/tb_top.sv
